// ----- design/ncq_pkg.sv -----
// ----------------------------------------------------------------------------
// Nearest codeword quantizer package
// Shared widths and the point and candidate types that travel along the
// chain of distance cells.
// ----------------------------------------------------------------------------
package ncq_pkg;

    localparam int COORD_BITS     = 16;
    localparam int DIST_BITS      = 33;
    localparam int IDX_BITS       = 3;
    localparam int MAX_CENTERS    = 8;
    localparam int CENTER_BITS    = 2 * COORD_BITS;
    localparam int CFG_INDEX_BITS = 4;
    localparam int IN_DATA_BITS   = 32;
    localparam int OUT_DATA_BITS  = 72;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
    } point_t;

    // Best codeword found so far for one item.
    typedef struct packed {
        logic [DIST_BITS-1:0]         dist_sq;
        logic signed [COORD_BITS-1:0] cy;
        logic signed [COORD_BITS-1:0] cx;
        logic [IDX_BITS-1:0]          idx;
    } cand_t;

endpackage

// ----- design/ncq_cell.sv -----
// ----------------------------------------------------------------------------
// Nearest codeword quantizer cell
// Holds one codeword's comparison. Stage one squares the coordinate
// differences, stage two sums them and keeps the nearer of this codeword and
// the candidate handed in by the previous cell.
// ----------------------------------------------------------------------------
module ncq_cell #(
    parameter int INDEX = 0,
    parameter int CW    = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             adv,
    input  logic [ncq_pkg::CENTER_BITS-1:0]  center,
    input  logic                             in_valid,
    input  ncq_pkg::point_t                  in_pt,
    input  ncq_pkg::cand_t                   in_best,
    output logic                             out_valid,
    output ncq_pkg::point_t                  out_pt,
    output ncq_pkg::cand_t                   out_best
);
    import ncq_pkg::*;

    localparam int SQ_W = 2 * CW;
    localparam int D_W  = 2 * CW + 1;

    logic signed [CW-1:0]     px;
    logic signed [CW-1:0]     py;
    logic signed [CW-1:0]     cx;
    logic signed [CW-1:0]     cy;
    logic signed [CW:0]       dx;
    logic signed [CW:0]       dy;
    logic signed [2*CW+1:0]   prod_x;
    logic signed [2*CW+1:0]   prod_y;

    logic                     v1_reg;
    point_t                   pt1_reg;
    cand_t                    best1_reg;
    logic [SQ_W-1:0]          sqx_reg;
    logic [SQ_W-1:0]          sqy_reg;

    logic [D_W-1:0]           sum_sq;
    logic [DIST_BITS-1:0]     dist_ext;
    logic                     take;
    cand_t                    own;
    cand_t                    best2_next;

    logic                     v2_reg;
    point_t                   pt2_reg;
    cand_t                    best2_reg;

    // Stage one: differences and squares.
    always_comb
    begin
        px     = in_pt.x[CW-1:0];
        py     = in_pt.y[CW-1:0];
        cx     = center[COORD_BITS +: CW];
        cy     = center[CW-1:0];
        dx     = (CW+1)'(px) - (CW+1)'(cx);
        dy     = (CW+1)'(py) - (CW+1)'(cy);
        prod_x = dx * dx;
        prod_y = dy * dy;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pt1_reg   <= in_pt;
            best1_reg <= in_best;
            sqx_reg   <= prod_x[SQ_W-1:0];
            sqy_reg   <= prod_y[SQ_W-1:0];
            pt2_reg   <= pt1_reg;
            best2_reg <= best2_next;
        end
    end

    // Stage two: sum and compare. The first cell always takes its own
    // codeword; later cells replace the candidate only when strictly nearer,
    // so the lowest index wins a tie.
    always_comb
    begin
        sum_sq      = {1'b0, sqx_reg} + {1'b0, sqy_reg};
        dist_ext    = DIST_BITS'(sum_sq);
        own.dist_sq = dist_ext;
        own.cx      = COORD_BITS'(signed'(center[COORD_BITS +: CW]));
        own.cy      = COORD_BITS'(signed'(center[CW-1:0]));
        own.idx     = IDX_BITS'(INDEX);
        take        = (INDEX == 0) || (dist_ext < best1_reg.dist_sq);
        best2_next  = take ? own : best1_reg;
    end

    assign out_valid = v2_reg;
    assign out_pt    = pt2_reg;
    assign out_best  = best2_reg;

`ifndef SYNTHESIS
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        adv && v1_reg |=> v2_reg)
        else $error("ncq_cell: item lost between stages");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> (v1_reg == $past(v1_reg)) && (v2_reg == $past(v2_reg)))
        else $error("ncq_cell: valid bits moved during a stall");
    a_index: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg |-> best2_reg.idx <= IDX_BITS'(INDEX))
        else $error("ncq_cell: candidate index beyond this cell");
`endif

endmodule

// ----- design/nearest_codeword_quantizer_unit.sv -----
// ----------------------------------------------------------------------------
// Nearest codeword quantizer unit
// Finds the nearest of up to eight two-dimensional codewords for each point.
// ----------------------------------------------------------------------------
// The unit takes one point per cycle and returns one result per point, in
// order, once the point has passed every cell of the chain (NUM_CENTERS clamped to
// 1..8): each codeword has its own two-stage cell (square the differences,
// then sum and compare), and the cells form one chain that the points walk
// along. The whole chain stalls only while the final result is held and not
// taken. Codewords are written through the cfg port and must be changed only
// while no item is in flight.
// Coordinates use the low min(COORD_WIDTH, 16) bits, sign-extended.
module nearest_codeword_quantizer_unit #(
    parameter int NUM_CENTERS = 8,
    parameter int COORD_WIDTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [ncq_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [ncq_pkg::CENTER_BITS-1:0]     cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // point_x [15:0], point_y [31:16]
    input  logic [ncq_pkg::IN_DATA_BITS-1:0]    s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // center_index [2:0], center_x [18:3], center_y [34:19],
    // distance_sq [67:35], zeros [71:68]
    output logic [ncq_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata
);
    import ncq_pkg::*;

    localparam int NC = (NUM_CENTERS < 1) ? 1 :
                        ((NUM_CENTERS > MAX_CENTERS) ? MAX_CENTERS : NUM_CENTERS);
    localparam int CW = (COORD_WIDTH < COORD_BITS) ? COORD_WIDTH : COORD_BITS;
    localparam int PAD_BITS = OUT_DATA_BITS - DIST_BITS - 2 * COORD_BITS - IDX_BITS;

    logic [CENTER_BITS-1:0] center_reg [NC];
    logic                   adv;
    logic                   v_chain    [NC+1];
    point_t                 pt_chain   [NC+1];
    cand_t                  best_chain [NC+1];
    logic signed [CW-1:0]   in_x;
    logic signed [CW-1:0]   in_y;
    cand_t                  result;

    for (genvar k = 0; k < NC; k++)
    begin : g_center
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                center_reg[k] <= '0;
            else if (cfg_we && (cfg_index == CFG_INDEX_BITS'(k)))
                center_reg[k] <= cfg_data;
        end
    end

    assign adv           = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    always_comb
    begin
        in_x          = s_axis_tdata[CW-1:0];
        in_y          = s_axis_tdata[COORD_BITS +: CW];
        v_chain[0]    = s_axis_tvalid;
        pt_chain[0].x = COORD_BITS'(in_x);
        pt_chain[0].y = COORD_BITS'(in_y);
        best_chain[0] = '0;
    end

    for (genvar k = 0; k < NC; k++)
    begin : g_cell
        ncq_cell #(
            .INDEX (k),
            .CW    (CW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .center    (center_reg[k]),
            .in_valid  (v_chain[k]),
            .in_pt     (pt_chain[k]),
            .in_best   (best_chain[k]),
            .out_valid (v_chain[k+1]),
            .out_pt    (pt_chain[k+1]),
            .out_best  (best_chain[k+1])
        );
    end

    assign result        = best_chain[NC];
    assign m_axis_tvalid = v_chain[NC];
    assign m_axis_tdata  = {PAD_BITS'(0), result.dist_sq, result.cy, result.cx,
                            result.idx};

`ifndef SYNTHESIS
    a_out_index: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (int'(m_axis_tdata[IDX_BITS-1:0]) < NC))
        else $error("nearest_codeword_quantizer_unit: index beyond codebook");
    a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((m_axis_tdata[OUT_DATA_BITS-1 -: PAD_BITS + DIST_BITS]
                            >> (2 * CW + 1)) == '0))
        else $error("nearest_codeword_quantizer_unit: distance out of range");
`endif

endmodule
